// ===== rtl/quoted_csv_column_splitter_top_assert.svh =====
// Assertion macros shared by the column splitter modules.
// Each macro expects clk_i and rst_ni to be visible in the using module.
`ifndef QUOTED_CSV_COLUMN_SPLITTER_TOP_ASSERT_SVH
`define QUOTED_CSV_COLUMN_SPLITTER_TOP_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define CSVSPLIT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// A condition that must never be seen outside reset.
`define CSVSPLIT_ASSERT_NEVER(lbl, expr, msg) \
  `CSVSPLIT_ASSERT(lbl, !(expr), msg)

`endif

// ===== rtl/csvsplit_pkg.sv =====
// Types and constants of the quoted CSV column splitter.
// Used by the front, queue, emit and top-level modules; depends on nothing.
package csvsplit_pkg;

  // Characters that steer the parser.
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;

  // Longest row in bytes; offsets at or past this raise the row-too-long error.
  localparam int unsigned MaxRowBytes = 32'd65535;

  // Depth of the record-group queue between front and back.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // Kinds of output record.
  typedef enum logic [1:0] {
    KindSpan   = 2'd0,
    KindRowEnd = 2'd1,
    KindError  = 2'd2
  } record_kind_e;

  // Error codes.
  typedef enum logic [1:0] {
    ErrNone         = 2'd0,
    ErrQuoteNoComma = 2'd1,
    ErrMidCellQuote = 2'd2,
    ErrRowTooLong   = 2'd3
  } error_code_e;

  // One input item.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       row_last;
  } csv_in_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  record_kind;
    logic [15:0] span_start;
    logic [15:0] span_end;
    logic [15:0] column_number;
    logic [1:0]  error_code;
    logic [15:0] error_position;
    logic [31:0] row_index;
    logic        row_done;
  } csv_out_t;

  // All records caused by one input byte, at most three.
  typedef struct packed {
    logic [1:0]           count;
    csv_out_t [2:0]       recs;
  } rec_bundle_t;

endpackage

// ===== rtl/csvsplit_front.sv =====
// Front part of the column splitter: accepts bytes and classifies them.
// Depends on csvsplit_pkg; pushes at most one record group per byte into the queue.
module csvsplit_front
  import csvsplit_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  csv_in_t     in_data_i,
  input  logic        full_i,
  output logic        push_o,
  output rec_bundle_t push_data_o
);

  // Parser state that is carried from one judged byte to the next.
  typedef struct packed {
    logic [7:0]  before_byte;
    logic        in_quotes;
    logic        escape_pending;
    logic [15:0] column_begin;
    logic [15:0] column_count;
    logic        row_failed;
  } parse_state_t;

  typedef struct packed {
    parse_state_t st;
    logic         rec_v;
    csv_out_t     rec;
  } judge_t;

  // Build one record with the unused fields cleared.
  function automatic csv_out_t make_rec(logic [1:0] kind, logic [15:0] s, logic [15:0] e,
                                        logic [15:0] col, logic [1:0] code,
                                        logic [15:0] epos, logic [31:0] row);
    csv_out_t r;
    r.record_kind    = kind;
    r.span_start     = s;
    r.span_end       = e;
    r.column_number  = col;
    r.error_code     = code;
    r.error_position = epos;
    r.row_index      = row;
    r.row_done       = 1'b0;
    return r;
  endfunction

  // Judge one byte with its successor; gives at most one record.
  function automatic judge_t judge(parse_state_t st, logic [7:0] c, logic [7:0] nxt,
                                   logic [15:0] pos, logic at_end, logic [31:0] row);
    judge_t j;
    j.st    = st;
    j.rec_v = 1'b0;
    j.rec   = '0;
    // A comma outside quotes closes the column, even when escaped.
    if (!st.in_quotes && c == ChComma) begin
      j.rec_v           = 1'b1;
      j.rec             = make_rec(KindSpan, st.column_begin, pos, st.column_count,
                                   ErrNone, 16'd0, row);
      j.st.column_count = st.column_count + 16'd1;
      j.st.column_begin = pos + 16'd1;
    end
    if (c == ChBslash) begin
      j.st.escape_pending = !st.escape_pending;
    end else if (st.escape_pending) begin
      j.st.escape_pending = 1'b0;
    end else if (st.in_quotes && c == ChQuote) begin
      // A closing quote must be followed by a comma or the row end.
      if (at_end || nxt == ChComma) begin
        j.st.in_quotes = 1'b0;
      end else begin
        j.rec_v         = 1'b1;
        j.rec           = make_rec(KindError, 16'd0, 16'd0, st.column_count,
                                   ErrQuoteNoComma, pos, row);
        j.st.row_failed = 1'b1;
      end
    end else if (!st.in_quotes && c == ChQuote) begin
      // A quote may only open a cell at the row start or after a comma.
      if (pos != 16'd0 && st.before_byte != ChComma) begin
        j.rec_v         = 1'b1;
        j.rec           = make_rec(KindError, 16'd0, 16'd0, st.column_count,
                                   ErrMidCellQuote, pos, row);
        j.st.row_failed = 1'b1;
      end else begin
        j.st.in_quotes = 1'b1;
      end
    end
    j.st.before_byte = c;
    return j;
  endfunction

  parse_state_t st_q, st_d;
  logic [7:0]   held_byte_q, held_byte_d;
  logic         held_valid_q, held_valid_d;
  logic [15:0]  pos_q, pos_d;
  logic [31:0]  row_q, row_d;
  rec_bundle_t  bundle;
  logic         in_fire;

  assign in_fire = in_valid_i && !full_i;

  // Per-byte step: judge the held byte, then take the new one.
  always_comb begin
    parse_state_t st;
    judge_t       jr;
    logic [1:0]   n;
    st           = st_q;
    held_byte_d  = held_byte_q;
    held_valid_d = held_valid_q;
    pos_d        = pos_q;
    row_d        = row_q;
    bundle       = '0;
    n            = 2'd0;
    jr           = '0;
    if (!st_q.row_failed) begin
      if (held_valid_q) begin
        jr = judge(st, held_byte_q, in_data_i.data_byte, pos_q - 16'd1, 1'b0, row_q);
        st = jr.st;
        if (jr.rec_v) begin
          bundle.recs[n] = jr.rec;
          n = n + 2'd1;
        end
      end
      if (!st.row_failed) begin
        if (32'(pos_q) >= MaxRowBytes || pos_q == 16'hFFFF) begin
          bundle.recs[n] = make_rec(KindError, 16'd0, 16'd0, st.column_count,
                                    ErrRowTooLong, pos_q, row_q);
          n = n + 2'd1;
          st.row_failed = 1'b1;
        end else if (in_data_i.row_last) begin
          jr = judge(st, in_data_i.data_byte, in_data_i.data_byte, pos_q, 1'b1, row_q);
          st = jr.st;
          if (jr.rec_v) begin
            bundle.recs[n] = jr.rec;
            n = n + 2'd1;
          end
          pos_d        = pos_q + 16'd1;
          held_valid_d = 1'b0;
        end else begin
          held_byte_d  = in_data_i.data_byte;
          held_valid_d = 1'b1;
          pos_d        = pos_q + 16'd1;
        end
      end
    end
    // Row end: close the last column, report the row end or end on a new error, then clear.
    if (in_data_i.row_last) begin
      if (st.row_failed) begin
        if (st_q.row_failed || !(st.row_failed && !st_q.row_failed)) begin
          bundle.recs[n] = make_rec(KindRowEnd, 16'd0, 16'd0, st.column_count,
                                    ErrNone, 16'd0, row_q);
          n = n + 2'd1;
        end
      end else if (st.column_begin < pos_d) begin
        bundle.recs[n] = make_rec(KindSpan, st.column_begin, pos_d, st.column_count,
                                  ErrNone, 16'd0, row_q);
        n = n + 2'd1;
      end else begin
        bundle.recs[n] = make_rec(KindRowEnd, 16'd0, 16'd0, st.column_count,
                                  ErrNone, 16'd0, row_q);
        n = n + 2'd1;
      end
      // The last record of the group is always the one that ends the row.
      bundle.recs[n - 2'd1].row_done = 1'b1;
      st           = '0;
      held_byte_d  = 8'd0;
      held_valid_d = 1'b0;
      pos_d        = 16'd0;
      row_d        = row_q + 32'd1;
    end
    bundle.count = n;
    st_d         = st;
  end

  assign push_o      = in_fire && (bundle.count != 2'd0);
  assign push_data_o = bundle;

  // Parser registers advance on each transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= '0;
      held_byte_q  <= 8'd0;
      held_valid_q <= 1'b0;
      pos_q        <= 16'd0;
      row_q        <= 32'd0;
    end else if (in_fire) begin
      st_q         <= st_d;
      held_byte_q  <= held_byte_d;
      held_valid_q <= held_valid_d;
      pos_q        <= pos_d;
      row_q        <= row_d;
    end
  end

endmodule

// ===== rtl/csvsplit_queue.sv =====
// Queue of record groups between the front and the back of the splitter.
// Depends on csvsplit_pkg and the shared assertion macro header.
`include "quoted_csv_column_splitter_top_assert.svh"

module csvsplit_queue
  import csvsplit_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  rec_bundle_t push_data_i,
  output logic        full_o,
  input  logic        pop_i,
  output rec_bundle_t head_o,
  output logic        empty_o
);

  rec_bundle_t           slots_q [QueueDepth];
  logic [QPtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]      count_q;

  assign full_o  = (count_q == QCntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = slots_q[rd_ptr_q];

  // Storage is written only at the write pointer.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `CSVSPLIT_ASSERT_NEVER(a_push_when_full, push_i && full_o, "push into a full queue")
  `CSVSPLIT_ASSERT_NEVER(a_pop_when_empty, pop_i && empty_o, "pop from an empty queue")
  `CSVSPLIT_ASSERT(a_push_not_empty, push_i |-> push_data_i.count != 2'd0, "empty group pushed")
  `CSVSPLIT_ASSERT(a_count_bound, count_q <= QCntW'(QueueDepth), "queue count overflow")

endmodule

// ===== rtl/csvsplit_emit.sv =====
// Back part of the splitter: sends the records of each group one per transfer.
// Depends on csvsplit_pkg and the shared assertion macro header.
`include "quoted_csv_column_splitter_top_assert.svh"

module csvsplit_emit
  import csvsplit_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rec_bundle_t head_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output csv_out_t    out_data_o
);

  logic       out_valid_q;
  csv_out_t   out_q;
  logic [1:0] idx_q;
  logic       load;
  logic       last_rec;

  // The output register may take a new record when empty or being taken.
  assign load     = !out_valid_q || !out_stall_i;
  assign last_rec = (idx_q == head_i.count - 2'd1);
  assign pop_o    = load && !empty_i && last_rec;

  // Record index within the head group and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else if (load) begin
      out_valid_q <= !empty_i;
      if (!empty_i) begin
        idx_q <= last_rec ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && !empty_i) begin
      out_q <= head_i.recs[idx_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CSVSPLIT_ASSERT(a_idx_in_group, !empty_i |-> idx_q < head_i.count, "record index past group")
  `CSVSPLIT_ASSERT(a_idx_reset_empty, empty_i |-> idx_q == 2'd0, "stale index with empty queue")

endmodule

// ===== rtl/quoted_csv_column_splitter_top.sv =====
// Top level of the quoted CSV column splitter.
// Depends on csvsplit_pkg, csvsplit_front, csvsplit_queue and csvsplit_emit.
//
// The splitter takes one byte of a row per cycle while in_stall_o is
// low and gives column span, row-end and error records, one record per
// cycle while out_stall_i is low. Each byte is judged together with the
// byte after it, so the records caused by a byte appear when the next
// byte of the row (or the row end) is taken; one byte yields zero to
// three records. The front judges a byte in the cycle that takes its
// successor or the row end and writes its records as one group into a
// four-group queue; the back reads them out through an output register.
// Input is taken every cycle while the queue has room; the output port
// is the limit when bytes cause more than one record on average.
module quoted_csv_column_splitter_top
  import csvsplit_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  csv_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output csv_out_t out_data_o
);

  logic        push;
  rec_bundle_t push_data;
  logic        full;
  logic        pop;
  rec_bundle_t head;
  logic        empty;

  assign in_stall_o = full;

  // Byte parsing.
  csvsplit_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Record groups waiting for the output.
  csvsplit_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  // Record output.
  csvsplit_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
